FILE: hw/rtl/rrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_pkg: shared constants and the angle table for the rectangle corner rotator
// Holds the CORDIC angle table, the gain constant and the pivot corner select
// range that the front end, the back end and the bench use.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int GUARD_BITS = 16;
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;
  localparam int GAIN_SHIFT = 30 + GUARD_BITS;

  localparam logic [2:0] PIVOT_CORNER_FIRST = 3'd1;
  localparam logic [2:0] PIVOT_CORNER_LAST  = 3'd4;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] step_angle(input int idx);
    logic [31:0] tbl [0:31];
    tbl = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
            32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
            32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
            32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
            32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
            32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
    return tbl[idx[4:0]];
  endfunction

endpackage

FILE: hw/rtl/rotate_rectangle_corners_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_rectangle_corners_unit: rotates rectangle corners about a pivot
//
// channel | direction | payload
// in_     | slave     | rectangle, pivot select, direction, angle
// out_    | master    | one rotated corner, tlast on the fourth
//
// One request yields four corners, one per cycle while the output does not
// stall; the front end takes the next request as it issues the fourth corner.
// Synchronous active-low reset clears only the valid and pointer state.
// A stalled output freezes the pipe; the two-entry queue absorbs the front.
// ----------------------------------------------------------------------------
module rotate_rectangle_corners_unit import rrc_pkg::*; #(
  parameter int COORD_WIDTH     = 24,
  parameter int ANGLE_WIDTH     = 16,
  parameter int ROTATION_STAGES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // center_x, center_y, width, height, pivot_select, clockwise, angle
  input  logic [((4*COORD_WIDTH+ANGLE_WIDTH+2)+7)/8*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // corner_x, corner_y, corner_index, saturated
  output logic [((2*COORD_WIDTH+3)+7)/8*8-1:0] out_tdata,
  output logic out_tlast
);
  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int QW = 4*(CW+2)+AW+2;
  localparam int OW = ((2*CW+3)+7)/8*8;

  logic          q_iv, q_ir, q_ov, q_or;
  logic [QW-1:0] q_id, q_od;
  logic signed [CW-1:0] cx, cy;
  logic [1:0]    ci;
  logic          sat;

  rrc_front #(.CW(CW), .AW(AW)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .center_x(in_tdata[CW-1:0]),
    .center_y(in_tdata[2*CW-1:CW]),
    .width(in_tdata[3*CW-2:2*CW]),
    .height(in_tdata[4*CW-3:3*CW-1]),
    .pivot_select(in_tdata[4*CW:4*CW-2]),
    .clockwise(in_tdata[4*CW+1]),
    .angle(in_tdata[4*CW+AW+1:4*CW+2]),
    .q_valid(q_iv), .q_ready(q_ir), .q_data(q_id)
  );

  rrc_queue #(.DW(QW)) u_queue (
    .clk, .rst_n,
    .s_valid(q_iv), .s_ready(q_ir), .s_data(q_id),
    .m_valid(q_ov), .m_ready(q_or), .m_data(q_od)
  );

  rrc_back #(.CW(CW), .AW(AW), .NS(ROTATION_STAGES)) u_back (
    .clk, .rst_n,
    .s_valid(q_ov), .s_ready(q_or), .s_data(q_od),
    .m_valid(out_tvalid), .m_ready(out_tready),
    .corner_x(cx), .corner_y(cy), .corner_index(ci),
    .last_corner(out_tlast), .saturated(sat)
  );

  assign out_tdata = OW'({sat, ci, cy, cx});
endmodule

FILE: hw/rtl/rrc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_front: corner and pivot former
// Accepts one rectangle request, forms the four corners and the pivot at one
// fraction bit and pushes one corner request per cycle into the queue while it has room.
// ----------------------------------------------------------------------------
module rrc_front import rrc_pkg::*; #(
  parameter int CW = 24,
  parameter int AW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] center_x,
  input  logic signed [CW-1:0] center_y,
  input  logic [CW-2:0]        width,
  input  logic [CW-2:0]        height,
  input  logic [2:0]           pivot_select,
  input  logic                 clockwise,
  input  logic [AW-1:0]        angle,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic [2*(CW+2)+2*(CW+2)+AW+2-1:0] q_data
);
  localparam int PW = CW + 2;

  logic                 busy_r;
  logic [1:0]           k_r;
  logic signed [PW-1:0] cx_r, cy_r, px_r, py_r;
  logic [CW-2:0]        w_r, h_r;
  logic [AW-1:0]        a_r;

  logic signed [PW-1:0] cx2, cy2, wx, hx, kx, ky, dx, dy, pxn, pyn;
  logic signed [PW-1:0] sx, sy;
  logic [1:0]           psel;
  logic                 pcorner;

  assign in_ready = !busy_r || (q_ready && k_r == 2'd3);

  always_comb begin
    cx2 = {{1{center_x[CW-1]}}, center_x, 1'b0};
    cy2 = {{1{center_y[CW-1]}}, center_y, 1'b0};
    wx  = PW'({1'b0, width});
    hx  = PW'({1'b0, height});
    pcorner = pivot_select >= PIVOT_CORNER_FIRST && pivot_select <= PIVOT_CORNER_LAST;
    psel = 2'(pivot_select - PIVOT_CORNER_FIRST);
    sx = (psel == 2'd1 || psel == 2'd2) ? wx : -wx;
    sy = psel[1] ? hx : -hx;
    pxn = pcorner ? cx2 + sx : cx2;
    pyn = pcorner ? cy2 + sy : cy2;
    kx = cx_r + ((k_r == 2'd1 || k_r == 2'd2) ? PW'({1'b0, w_r}) : -PW'({1'b0, w_r}));
    ky = cy_r + (k_r[1] ? PW'({1'b0, h_r}) : -PW'({1'b0, h_r}));
    dx = kx - px_r;
    dy = py_r - ky;
  end

  assign q_valid = busy_r;
  assign q_data  = {k_r, a_r, py_r, px_r, dy, dx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 2'd0;
    end else begin
      if (busy_r && q_ready) begin
        k_r <= k_r + 2'd1;
        if (k_r == 2'd3) busy_r <= 1'b0;
      end
      if (in_valid && in_ready) begin
        busy_r <= 1'b1;
        k_r    <= 2'd0;
      end
    end
    if (in_valid && in_ready) begin
      cx_r <= cx2;
      cy_r <= cy2;
      w_r  <= width;
      h_r  <= height;
      px_r <= pxn;
      py_r <= pyn;
      a_r  <= clockwise ? AW'(~angle + 1'b1) : angle;
    end
  end
endmodule

FILE: hw/rtl/rrc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_queue: two-entry request queue
// Decouples the corner former from the rotation pipeline.
// ----------------------------------------------------------------------------
module rrc_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s_valid,
  output logic          s_ready,
  input  logic [DW-1:0] s_data,
  output logic          m_valid,
  input  logic          m_ready,
  output logic [DW-1:0] m_data
);
  logic [DW-1:0] mem_r [0:1];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push, pop;

  assign s_ready = cnt_r != 2'd2;
  assign m_valid = cnt_r != 2'd0;
  assign m_data  = mem_r[rp_r];
  assign push = s_valid && s_ready;
  assign pop  = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= s_data;
  end
endmodule

FILE: hw/rtl/rrc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_back: pipelined rotation back end
// Quarter-turn fold, CORDIC stages, gain correction and saturation, one
// corner a cycle; the whole pipe advances only when the output can take data.
// ----------------------------------------------------------------------------
module rrc_back import rrc_pkg::*; #(
  parameter int CW = 24,
  parameter int AW = 16,
  parameter int NS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  logic [4*(CW+2)+AW+2-1:0] s_data,
  output logic                 m_valid,
  input  logic                 m_ready,
  output logic signed [CW-1:0] corner_x,
  output logic signed [CW-1:0] corner_y,
  output logic [1:0]           corner_index,
  output logic                 last_corner,
  output logic                 saturated
);
  localparam int PW = CW + 2;                 // vector at 1 fraction bit
  localparam int VW = PW + GUARD_BITS + 3;    // CORDIC datapath
  localparam int ZW = 34;
  localparam int NL = NS + 4;                 // pipeline depth

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 rot;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic [1:0]           k;
  } stg_t;

  logic                 adv;
  logic [NL-1:0]        v_r;
  stg_t                 st_r [0:NS];
  logic signed [PW-1:0] in_dx, in_dy, in_px, in_py;
  logic [AW-1:0]        in_a;
  logic [1:0]           in_k;
  logic [AW-1:0]        qu, rr;
  logic signed [PW-1:0] fx, fy;
  stg_t                 s0;

  assign {in_k, in_a, in_py, in_px, in_dy, in_dx} = s_data;
  assign adv = !m_valid || m_ready;
  assign s_ready = adv;

  always_comb begin
    qu = (in_a + AW'(1 << (AW - 3))) >> (AW - 2);
    rr = in_a - (qu << (AW - 2));
    unique case (qu[1:0])
      2'd0: begin fx = in_dx;  fy = in_dy;  end
      2'd1: begin fx = -in_dy; fy = in_dx;  end
      2'd2: begin fx = -in_dx; fy = -in_dy; end
      default: begin fx = in_dy; fy = -in_dx; end
    endcase
    s0.rot = rr != '0;
    s0.x = s0.rot ? VW'(fx) <<< GUARD_BITS : VW'(fx);
    s0.y = s0.rot ? VW'(fy) <<< GUARD_BITS : VW'(fy);
    s0.z = ZW'($signed(rr)) <<< (32 - AW);
    s0.px = in_px;
    s0.py = in_py;
    s0.k = in_k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NL-2:0], s_valid};
    if (adv) st_r[0] <= s0;
  end

  genvar i;
  generate
    for (i = 0; i < NS; i++) begin : g_cordic
      stg_t nx;
      always_comb begin
        nx = st_r[i];
        if (st_r[i].rot) begin
          if (!st_r[i].z[ZW-1]) begin
            nx.x = st_r[i].x - (st_r[i].y >>> i);
            nx.y = st_r[i].y + (st_r[i].x >>> i);
            nx.z = st_r[i].z - ZW'(step_angle(i));
          end else begin
            nx.x = st_r[i].x + (st_r[i].y >>> i);
            nx.y = st_r[i].y - (st_r[i].x >>> i);
            nx.z = st_r[i].z + ZW'(step_angle(i));
          end
        end
      end
      always_ff @(posedge clk) if (adv) st_r[i+1] <= nx;
    end
  endgenerate

  // gain: split magnitude into two 32x30 products
  localparam int MW = 64;
  logic [MW-1:0]        mx, my;
  logic                 nxs, nys;
  logic [MW-1:0]        phx_r, plx_r, phy_r, ply_r;
  logic                 gsx_r, gsy_r, grot_r;
  stg_t                 g_r;
  logic [MW-1:0]        qx, qy;
  logic signed [VW-1:0] gx, gy;
  logic signed [PW+2:0] ox2_r, oy2_r;
  logic [1:0]           ok_r;

  always_comb begin
    nxs = st_r[NS].x[VW-1];
    nys = st_r[NS].y[VW-1];
    mx = MW'(nxs ? -st_r[NS].x : st_r[NS].x);
    my = MW'(nys ? -st_r[NS].y : st_r[NS].y);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      phx_r <= MW'(mx[MW-1:32]) * MW'(GAIN_Q30);
      plx_r <= MW'(mx[31:0]) * MW'(GAIN_Q30);
      phy_r <= MW'(my[MW-1:32]) * MW'(GAIN_Q30);
      ply_r <= MW'(my[31:0]) * MW'(GAIN_Q30);
      gsx_r <= nxs;
      gsy_r <= nys;
      grot_r <= st_r[NS].rot;
      g_r <= st_r[NS];
    end
  end

  always_comb begin
    qx = (phx_r + (plx_r >> 32) + (MW'(1) << (GAIN_SHIFT - 33))) >> (GAIN_SHIFT - 32);
    qy = (phy_r + (ply_r >> 32) + (MW'(1) << (GAIN_SHIFT - 33))) >> (GAIN_SHIFT - 32);
    gx = grot_r ? (gsx_r ? -VW'(qx) : VW'(qx)) : g_r.x;
    gy = grot_r ? (gsy_r ? -VW'(qy) : VW'(qy)) : g_r.y;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox2_r <= (PW+3)'(g_r.px) + (PW+3)'(gx) + (PW+3)'(1);
      oy2_r <= (PW+3)'(g_r.py) - (PW+3)'(gy) + (PW+3)'(1);
      ok_r  <= g_r.k;
    end
  end

  // halve with floor, then clip
  logic signed [PW+1:0] hx, hy;
  logic                 sxh, sxl, syh, syl;
  logic signed [CW-1:0] cxo, cyo;
  logic signed [PW+1:0] hi_v, lo_v;
  always_comb begin
    hx = ox2_r[PW+2:1];
    hy = oy2_r[PW+2:1];
    hi_v = (PW+2)'({1'b0, {(CW-1){1'b1}}});
    lo_v = ~hi_v;
    sxh = hx > hi_v;
    sxl = hx < lo_v;
    syh = hy > hi_v;
    syl = hy < lo_v;
    cxo = sxh ? hi_v[CW-1:0] : sxl ? lo_v[CW-1:0] : hx[CW-1:0];
    cyo = syh ? hi_v[CW-1:0] : syl ? lo_v[CW-1:0] : hy[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      corner_x     <= cxo;
      corner_y     <= cyo;
      corner_index <= ok_r;
      last_corner  <= ok_r == 2'd3;
      saturated    <= sxh | sxl | syh | syl;
    end
  end

  assign m_valid = v_r[NL-1];
endmodule

FILE: tb/sv/rotate_rectangle_corners_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_rectangle_corners_unit_tb: self-checking bench for the corner rotator
// Sends rectangles with a pivot, direction and angle, predicts the four
// rotated corners of each with a bit-exact CORDIC model, and compares every
// corner the block returns under random gaps and output stalls.
// ----------------------------------------------------------------------------
module rotate_rectangle_corners_unit_tb;
  import rrc_pkg::*;

  localparam int CW = 24;
  localparam int AW = 16;
  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 5;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [1:0]    idx;
    logic          last;
    logic          sat;
  } corner_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [119:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [55:0] out_tdata;
  logic out_tlast;

  corner_t corner_q[$];
  int errors = 0;
  int n_items = 0;
  int n_corners = 0;
  int n_sat = 0;
  int hold_cycles = 0;
  longint cycles = 0;

  rotate_rectangle_corners_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint gain_fix(input longint a);
    logic [63:0] m, ph, pl, q;
    m = (a < 0) ? -a : a;
    ph = (m >> 32) * 64'(GAIN_Q30);
    pl = (m & 64'hFFFF_FFFF) * 64'(GAIN_Q30);
    q = (ph + (pl >> 32) + (64'd1 << (GAIN_SHIFT - 33))) >> (GAIN_SHIFT - 32);
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  // rotate (x, y) counterclockwise in a y-up frame
  function automatic void rotate_vec(inout longint x, inout longint y,
                                     input longint a);
    longint quarter, qu, r, vx, vy, t, z, sx, sy;
    int q;
    quarter = longint'(1) << (AW - 2);
    qu = (a + (quarter >> 1)) >>> (AW - 2);
    r = a - qu * quarter;
    vx = x;
    vy = y;
    q = int'(qu & 3);
    repeat (q) begin
      t = vx;
      vx = -vy;
      vy = t;
    end
    if (r != 0) begin
      vx = vx * (longint'(1) << GUARD_BITS);
      vy = vy * (longint'(1) << GUARD_BITS);
      z = r * (longint'(1) << (32 - AW));
      for (int i = 0; i < STAGES; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (z >= 0) begin
          vx -= sy; vy += sx; z -= longint'(step_angle(i));
        end else begin
          vx += sy; vy -= sx; z += longint'(step_angle(i));
        end
      end
      vx = gain_fix(vx);
      vy = gain_fix(vy);
    end
    x = vx;
    y = vy;
  endfunction

  function automatic longint clip_coord(input longint v2, inout logic sat);
    longint hi, lo, v;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    v = (v2 + 1) >>> 1;
    if (v > hi) begin sat = 1'b1; return hi; end
    if (v < lo) begin sat = 1'b1; return lo; end
    return v;
  endfunction

  // push the four rotated corners of one accepted rectangle
  function automatic void predict_corners(input logic [119:0] d);
    longint cx2, cy2, w, h, px, py, dx, dy, ox, oy;
    longint kx[4], ky[4];
    logic [2:0] sel;
    logic [AW-1:0] a;
    logic sat;
    corner_t c;
    cx2 = 2 * longint'($signed(d[23:0]));
    cy2 = 2 * longint'($signed(d[47:24]));
    w = longint'(d[70:48]);
    h = longint'(d[93:71]);
    sel = d[96:94];
    a = d[113:98];
    if (d[97]) a = -a;
    for (int k = 0; k < 4; k++) begin
      kx[k] = cx2 + ((k == 1 || k == 2) ? w : -w);
      ky[k] = cy2 + ((k >= 2) ? h : -h);
    end
    if (sel >= PIVOT_CORNER_FIRST && sel <= PIVOT_CORNER_LAST) begin
      px = kx[sel - 1];
      py = ky[sel - 1];
    end else begin
      px = cx2;
      py = cy2;
    end
    for (int k = 0; k < 4; k++) begin
      dx = kx[k] - px;
      dy = py - ky[k];
      sat = 1'b0;
      rotate_vec(dx, dy, longint'(a));
      ox = clip_coord(px + dx, sat);
      oy = clip_coord(py - dy, sat);
      c.x = ox[CW-1:0];
      c.y = oy[CW-1:0];
      c.idx = k[1:0];
      c.last = (k == 3);
      c.sat = sat;
      corner_q.push_back(c);
    end
  endfunction

  // drive one request, wait for the handshake, then drop valid for the gap, if any
  task automatic send_rect(input logic [23:0] cx, input logic [23:0] cy,
                           input logic [22:0] w, input logic [22:0] h,
                           input logic [2:0] sel, input logic cw,
                           input logic [15:0] ang, input int gap);
    logic [119:0] d;
    d = {6'b0, ang, cw, sel, h, w, cy, cx};
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = d;
    do @(posedge clk); while (!in_tready);
    predict_corners(d);
    n_items++;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_random(input int gap);
    logic [23:0] cx, cy;
    logic [22:0] w, h;
    if ($urandom_range(0, 3) == 0) begin
      cx = $urandom; cy = $urandom; w = $urandom; h = $urandom;
    end else begin
      cx = $signed(20'($urandom)); cy = $signed(20'($urandom));
      w = 18'($urandom); h = 18'($urandom);
    end
    send_rect(cx, cy, w, h, 3'($urandom), 1'($urandom), 16'($urandom), gap);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (corner_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [15:0] quarters[4];
    quarters = '{16'h0000, 16'h4000, 16'h8000, 16'hC000};
    for (int p = 0; p < 8; p++)
      send_rect(24'h000100, 24'hFFFE00, 23'h000A00, 23'h000400, 3'(p),
                1'(p), 16'h1555, pick_gap());
    foreach (quarters[i])
      send_rect(24'h001000, 24'h002000, 23'h000300, 23'h000500, 3'd2, 1'b0,
                quarters[i], 0);
    send_rect(24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 3'd0, 1'b0,
              16'h2000, 0);
    send_rect(24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 3'd3, 1'b1,
              16'hFFFF, 1);
    send_rect(24'h000000, 24'h000000, 23'h000000, 23'h000000, 3'd0, 1'b0,
              16'h1FFF, 0);
    send_rect(24'h123456, 24'hABCDEF, 23'h000001, 23'h000001, 3'd4, 1'b1,
              16'hE000, 0);
    send_rect(24'h000000, 24'h000000, 23'h7FFFFF, 23'h000000, 3'd5, 1'b0,
              16'h6000, 2);
    send_rect(24'h7FFFFF, 24'h000000, 23'h400000, 23'h400000, 3'd1, 1'b0,
              16'h2001, 0);
    send_rect(24'h555555, 24'hAAAAAA, 23'h2AAAAA, 23'h555555, 3'd7, 1'b1,
              16'h5555, 0);
    send_rect(24'hAAAAAA, 24'h555555, 23'h555555, 23'h2AAAAA, 3'd6, 1'b0,
              16'hAAAA, 0);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_random(pick_gap());
  endtask

  // hold the output long enough to fill the pipe and stall the input
  task automatic test_backpressure();
    hold_cycles = 120;
    for (int i = 0; i < 16; i++) send_random(0);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++) send_random(0);
    wait_drained();
    for (int i = 0; i < 6; i++) send_random(pick_gap());
  endtask

  // receiver stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) < 70) ||
                    (($urandom_range(0, 99) < 50) && (cycles % 512 < 128));
    end
  end

  // compare each returned corner with the oldest expectation
  always @(posedge clk) begin
    corner_t c, e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      c.x = out_tdata[23:0];
      c.y = out_tdata[47:24];
      c.idx = out_tdata[49:48];
      c.sat = out_tdata[50];
      c.last = out_tlast;
      n_corners++;
      if (corner_q.size() == 0) begin
        $display("%0t: unexpected corner x=%h y=%h", $time, c.x, c.y);
        errors++;
      end else begin
        e = corner_q.pop_front();
        if (c.sat) n_sat++;
        if (c !== e) begin
          $display("%0t: corner mismatch exp x=%h y=%h idx=%0d last=%b sat=%b",
                   $time, e.x, e.y, e.idx, e.last, e.sat);
          $display("%0t:                 got x=%h y=%h idx=%0d last=%b sat=%b",
                   $time, c.x, c.y, c.idx, c.last, c.sat);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random(110);
    test_drain_pause();
    test_random(110);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (corner_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    $display("Sent %0d rectangles, checked %0d corners (%0d saturated),",
             n_items, n_corners, n_sat);
    $display("with all pivots, both directions, quarter turns and stalls.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rrc_pkg.sv
hw/rtl/rrc_front.sv
hw/rtl/rrc_queue.sv
hw/rtl/rrc_back.sv
hw/rtl/rotate_rectangle_corners_unit.sv
tb/sv/rotate_rectangle_corners_unit_tb.sv
